// ===== src/lca_pkg.sv =====
// shared constants and types for the binary lifting lowest common ancestor block
// no dependencies
package lca_pkg;

    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 11;

    localparam int NODE_W   = 10;
    localparam int PARENT_W = 11;
    localparam int DEPTH_W  = 10;
    localparam int OUT_W    = 10;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               loaded;
        logic [DEPTH_W-1:0] depth;
    } info_t;

    typedef struct packed {
        logic  rd;
        logic  wr;
        info_t wdata;
    } info_req_t;

endpackage

// ===== src/lca_info_mem.sv =====
// per node memory: loaded mark and depth, one access per cycle once the clearing sweep is done, registered read
// sweeps every entry clear after reset; depends on lca_pkg
module lca_info_mem #(
    parameter int NODES = lca_pkg::NODES_DEF,
    localparam int AW = $clog2(NODES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lca_pkg::info_req_t req,
    input  logic [AW-1:0]     addr,
    output lca_pkg::info_t    rdata,
    output logic              clearing
);
    import lca_pkg::*;

    info_t         mem [NODES];
    info_t         rdata_reg;
    logic [AW-1:0] clr_idx_reg;
    logic [AW-1:0] clr_idx_next;
    logic          clr_reg;
    logic          clr_next;

    always_comb
    begin
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg)
        begin
            if (clr_idx_reg == AW'(NODES - 1))
                clr_next = 1'b0;
            else
                clr_idx_next = clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
            mem[clr_idx_reg] <= '0;
        else if (req.wr)
            mem[addr] <= req.wdata;
        if (!clr_reg && req.rd)
            rdata_reg <= mem[addr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_reg;

endmodule

// ===== src/lca_binary_lifting.sv =====
// lowest common ancestor by binary lifting: sequencer and ancestor table memory
// depends on lca_pkg and lca_info_mem
//
// One word is taken at a time: start is honoured only while busy is low. After reset the
// block stays busy while the loaded marks are swept clear. An add writes the node's info
// and parent, then fills each ancestor level above the parent: it reads the level below
// while that ancestor is still inside the tree and writes none once it lies above the
// root. An add gives no result. A query reads both depths, lifts the deeper node by the
// digits of the depth difference, compares, then walks down the levels and finishes; a
// query with an unloaded or out of range node answers early with an error. The result
// shows on the cycle after the last step. The single port of the ancestor table, one
// read or write per cycle, sets the pace of these steps.
// Each result shows for one cycle with done high and cannot be held off: the receiver
// must take it then.
module lca_binary_lifting #(
    parameter int NODES  = lca_pkg::NODES_DEF,
    parameter int LEVELS = lca_pkg::LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         func,
    input  logic [lca_pkg::NODE_W-1:0]   node_a,
    input  logic [lca_pkg::PARENT_W-1:0] node_b,
    input  logic [lca_pkg::DEPTH_W-1:0]  node_depth,
    output logic                         done,
    output logic [lca_pkg::OUT_W-1:0]    common_ancestor,
    output logic                         query_error
);
    import lca_pkg::*;

    localparam int NDW    = $clog2(NODES + 1);
    localparam int NIW    = $clog2(NODES);
    localparam int KW     = $clog2(LEVELS + 1);
    localparam int DEPTHS = NODES * LEVELS;
    localparam int AAW    = $clog2(DEPTHS);
    localparam logic [NDW-1:0] NONE = NDW'(NODES);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_A_INFO  = 12'b0000_0000_0010,
        S_A_ROW   = 12'b0000_0000_0100,
        S_A_WR    = 12'b0000_0000_1000,
        S_Q_INFOB = 12'b0000_0001_0000,
        S_Q_CHK   = 12'b0000_0010_0000,
        S_Q_LIFT  = 12'b0000_0100_0000,
        S_Q_LWAIT = 12'b0000_1000_0000,
        S_Q_EQ    = 12'b0001_0000_0000,
        S_Q_DX    = 12'b0010_0000_0000,
        S_Q_DY    = 12'b0100_0000_0000,
        S_Q_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [NDW-1:0]     a_reg, a_next;
    logic [NDW-1:0]     b_reg, b_next;
    logic [DEPTH_W-1:0] dep_reg, dep_next;
    logic [NDW-1:0]     x_reg, x_next;
    logic [NDW-1:0]     y_reg, y_next;
    logic [NDW-1:0]     ux_reg, ux_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [DEPTH_W-1:0] diff_reg, diff_next;
    logic               lift_y_reg, lift_y_next;
    logic               pend_reg, pend_next;
    logic               last_reg, last_next;
    info_t              ia_reg, ia_next;
    logic               done_reg, done_next;
    logic [OUT_W-1:0]   ca_reg, ca_next;
    logic               err_reg, err_next;

    // ancestor table port
    logic [NDW-1:0]     anc_node;
    logic [KW-1:0]      anc_lvl;
    logic [AAW-1:0]     anc_addr;
    logic               anc_rd;
    logic               anc_wr;
    logic [NDW-1:0]     anc_wdata;
    logic [NDW-1:0]     anc_rdata_reg;
    logic [NDW-1:0]     anc_mem [DEPTHS];

    // node info port
    info_req_t          info_req;
    logic [NIW-1:0]     info_addr;
    info_t              info_rdata;
    logic               clearing;

    logic               a_in_ok;
    logic               b_in_ok;
    logic [NDW-1:0]     par;
    logic [NDW-1:0]     lnode;
    logic [NDW-1:0]     uy;
    logic [NDW-1:0]     xn;
    logic [NDW-1:0]     yn;
    logic [NDW-1:0]     z;
    logic               give;

    lca_info_mem #(
        .NODES(NODES)
    ) u_info (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (info_req),
        .addr    (info_addr),
        .rdata   (info_rdata),
        .clearing(clearing)
    );

    assign anc_addr = AAW'(AAW'(anc_node) * AAW'(LEVELS) + AAW'(anc_lvl));

    always_ff @(posedge clk)
    begin
        if (anc_wr)
            anc_mem[anc_addr] <= anc_wdata;
        if (anc_rd)
            anc_rdata_reg <= anc_mem[anc_addr];
    end

    assign a_in_ok = 32'(node_a) < NODES;
    assign b_in_ok = 32'(node_b) < NODES;
    assign lnode   = lift_y_reg ? y_reg : x_reg;
    assign uy      = (y_reg == NONE) ? NONE : anc_rdata_reg;
    assign par     = (b_reg != NONE && info_rdata.loaded) ? b_reg : NONE;

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        dep_next    = dep_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ux_next     = ux_reg;
        k_next      = k_reg;
        diff_next   = diff_reg;
        lift_y_next = lift_y_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;
        ia_next     = ia_reg;
        done_next   = 1'b0;
        ca_next     = ca_reg;
        err_next    = err_reg;

        anc_node  = x_reg;
        anc_lvl   = k_reg;
        anc_rd    = 1'b0;
        anc_wr    = 1'b0;
        anc_wdata = NONE;

        info_req  = '0;
        info_addr = NIW'(a_reg);

        xn   = x_reg;
        yn   = y_reg;
        z    = x_reg;
        give = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !clearing)
                begin
                    a_next   = NDW'(node_a);
                    b_next   = b_in_ok ? NDW'(node_b) : NONE;
                    dep_next = node_depth;
                    if (func == FUNC_ADD)
                    begin
                        if (a_in_ok)
                        begin
                            info_req.rd = b_in_ok;
                            info_addr   = NIW'(node_b);
                            state_next  = S_A_INFO;
                        end
                    end
                    else if (a_in_ok && b_in_ok)
                    begin
                        info_req.rd = 1'b1;
                        info_addr   = NIW'(node_a);
                        state_next  = S_Q_INFOB;
                    end
                    else
                    begin
                        give = 1'b1;
                        z    = NONE;
                    end
                end
            end

            S_A_INFO:
            begin
                info_req.wr     = 1'b1;
                info_req.wdata  = '{loaded: 1'b1, depth: dep_reg};
                info_addr       = NIW'(a_reg);
                anc_node        = a_reg;
                anc_lvl         = '0;
                anc_wr          = 1'b1;
                anc_wdata       = par;
                x_next          = par;
                k_next          = KW'(1);
                state_next      = S_A_ROW;
            end

            S_A_ROW:
            begin
                if (x_reg == NONE)
                begin
                    // above the root every level stays none
                    anc_node = a_reg;
                    anc_wr   = 1'b1;
                    if (k_reg == KW'(LEVELS - 1))
                        state_next = S_IDLE;
                    else
                        k_next = k_reg + 1'b1;
                end
                else
                begin
                    anc_lvl    = k_reg - 1'b1;
                    anc_rd     = 1'b1;
                    state_next = S_A_WR;
                end
            end

            S_A_WR:
            begin
                anc_node  = a_reg;
                anc_wr    = 1'b1;
                anc_wdata = anc_rdata_reg;
                x_next    = anc_rdata_reg;
                if (k_reg == KW'(LEVELS - 1))
                    state_next = S_IDLE;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_A_ROW;
                end
            end

            S_Q_INFOB:
            begin
                ia_next     = info_rdata;
                info_req.rd = 1'b1;
                info_addr   = NIW'(b_reg);
                x_next      = a_reg;
                y_next      = b_reg;
                state_next  = S_Q_CHK;
            end

            S_Q_CHK:
            begin
                if (!ia_reg.loaded || !info_rdata.loaded)
                begin
                    give = 1'b1;
                    z    = NONE;
                end
                else
                begin
                    if (ia_reg.depth > info_rdata.depth)
                    begin
                        diff_next   = ia_reg.depth - info_rdata.depth;
                        lift_y_next = 1'b0;
                    end
                    else
                    begin
                        diff_next   = info_rdata.depth - ia_reg.depth;
                        lift_y_next = 1'b1;
                    end
                    k_next     = '0;
                    state_next = S_Q_LIFT;
                end
            end

            S_Q_LIFT:
            begin
                if (diff_reg == '0 || k_reg == KW'(LEVELS))
                    state_next = S_Q_EQ;
                else if (diff_reg[0] && lnode != NONE)
                begin
                    anc_node   = lnode;
                    anc_rd     = 1'b1;
                    state_next = S_Q_LWAIT;
                end
                else
                begin
                    diff_next = diff_reg >> 1;
                    k_next    = k_reg + 1'b1;
                end
            end

            S_Q_LWAIT:
            begin
                if (lift_y_reg)
                    y_next = anc_rdata_reg;
                else
                    x_next = anc_rdata_reg;
                diff_next  = diff_reg >> 1;
                k_next     = k_reg + 1'b1;
                state_next = S_Q_LIFT;
            end

            S_Q_EQ:
            begin
                if (x_reg == y_reg)
                    give = 1'b1;
                else
                begin
                    k_next     = KW'(LEVELS - 2);
                    pend_next  = 1'b0;
                    last_next  = 1'b0;
                    state_next = S_Q_DX;
                end
            end

            S_Q_DX:
            begin
                // settle the pair read for the previous level before reading on
                if (pend_reg && ux_reg != uy)
                begin
                    xn = ux_reg;
                    yn = uy;
                end
                x_next   = xn;
                y_next   = yn;
                anc_node = xn;
                anc_rd   = (xn != NONE);
                if (pend_reg && last_reg)
                begin
                    anc_lvl    = '0;
                    state_next = S_Q_FIN;
                end
                else
                    state_next = S_Q_DY;
            end

            S_Q_DY:
            begin
                ux_next   = (x_reg == NONE) ? NONE : anc_rdata_reg;
                anc_node  = y_reg;
                anc_rd    = (y_reg != NONE);
                pend_next = 1'b1;
                if (k_reg == '0)
                    last_next = 1'b1;
                else
                    k_next = k_reg - 1'b1;
                state_next = S_Q_DX;
            end

            S_Q_FIN:
            begin
                give = 1'b1;
                z    = (x_reg == NONE) ? NONE : anc_rdata_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (give)
        begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (z >= NONE)
            begin
                err_next = 1'b1;
                ca_next  = '0;
            end
            else
            begin
                err_next = 1'b0;
                ca_next  = OUT_W'(z);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        dep_reg    <= dep_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ux_reg     <= ux_next;
        k_reg      <= k_next;
        diff_reg   <= diff_next;
        lift_y_reg <= lift_y_next;
        pend_reg   <= pend_next;
        last_reg   <= last_next;
        ia_reg     <= ia_next;
        ca_reg     <= ca_next;
        err_reg    <= err_next;
    end

    assign busy            = (state_reg != S_IDLE) || clearing;
    assign done            = done_reg;
    assign common_ancestor = ca_reg;
    assign query_error     = err_reg;

endmodule

// ===== src/lca_checker.sv =====
// port level checks for lca_binary_lifting, attached by bind
// depends on lca_pkg
module lca_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      func,
    input logic                      done,
    input logic [lca_pkg::OUT_W-1:0] common_ancestor,
    input logic                      query_error
);
    import lca_pkg::*;

    // the clearing sweep holds the block off straight after reset
    a_busy_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> busy)
        else $error("block not busy after reset");

    // a failed query reports ancestor zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && query_error |-> common_ancestor == '0)
        else $error("error result with nonzero ancestor");

    // a result word leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // an add word never answers at once
    a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FUNC_ADD |=> !done)
        else $error("result after add word");

    // every result has a query or work in flight behind it
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || (start && func == FUNC_QUERY)))
        else $error("result without a query");

endmodule

bind lca_binary_lifting lca_checker u_lca_checker (.*);

// ===== tb/sv/tb_top.sv =====
// testbench for lca_binary_lifting: directed cases and random forests are loaded and queried against a predictor
// depends on lca_pkg and the lca_binary_lifting rtl
module tb_top;

    import lca_pkg::*;

    localparam int NODES       = NODES_DEF;
    localparam int LEVELS      = LEVELS_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 60;
    localparam logic [PARENT_W-1:0] NO_NODE = PARENT_W'(NODES);

    typedef struct packed {
        logic [OUT_W-1:0] anc;
        logic             err;
    } lca_answer_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic                func       = FUNC_ADD;
    logic [NODE_W-1:0]   node_a     = '0;
    logic [PARENT_W-1:0] node_b     = '0;
    logic [DEPTH_W-1:0]  node_depth = '0;
    logic                busy;
    logic                done;
    logic [OUT_W-1:0]    common_ancestor;
    logic                query_error;

    // predictor state
    logic [PARENT_W-1:0] tree_anc [NODES][LEVELS];
    logic [DEPTH_W-1:0]  tree_depth [NODES];
    bit                  tree_loaded [NODES];

    lca_answer_t         answer_q [$];
    logic [NODE_W-1:0]   fresh_pool [NODES];
    int                  pool_pos     = 0;
    int                  calm_left    = 0;
    int                  mismatches   = 0;
    int                  quiet_cycles = 0;

    always #6 clk = ~clk;

    lca_binary_lifting #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .node_a          (node_a),
        .node_b          (node_b),
        .node_depth      (node_depth),
        .done            (done),
        .common_ancestor (common_ancestor),
        .query_error     (query_error)
    );

    function automatic logic [PARENT_W-1:0] hop(input logic [PARENT_W-1:0] node, input int level);
        if (node >= NODES || level >= LEVELS)
            return NO_NODE;
        return tree_anc[node[NODE_W-1:0]][level];
    endfunction

    function automatic logic [PARENT_W-1:0] lift_node(input logic [PARENT_W-1:0] node,
                                                      input logic [DEPTH_W-1:0] diff);
        logic [PARENT_W-1:0] x;
        x = node;
        for (int k = 0; k < LEVELS && k < DEPTH_W; k++)
            if (diff[k])
                x = hop(x, k);
        return x;
    endfunction

    function automatic void record_add(input logic [NODE_W-1:0] node,
                                       input logic [PARENT_W-1:0] parent,
                                       input logic [DEPTH_W-1:0] d);
        logic [PARENT_W-1:0] up;
        if (node >= NODES)
            return;
        up = parent;
        if (parent >= NODES)
            up = NO_NODE;
        else if (!tree_loaded[parent[NODE_W-1:0]])
            up = NO_NODE;
        tree_depth[node]  = d;
        tree_loaded[node] = 1'b1;
        tree_anc[node][0] = up;
        // row is built in order, so a node that names itself sees its new entries
        for (int k = 1; k < LEVELS; k++)
            tree_anc[node][k] = hop(tree_anc[node][k-1], k - 1);
    endfunction

    function automatic lca_answer_t answer_query(input logic [NODE_W-1:0] a,
                                                 input logic [PARENT_W-1:0] b);
        lca_answer_t         r;
        logic [PARENT_W-1:0] x, y, ux, uy;
        logic [DEPTH_W-1:0]  dx, dy;
        r.anc = '0;
        r.err = 1'b1;
        if (a >= NODES || b >= NODES)
            return r;
        if (!tree_loaded[a] || !tree_loaded[b[NODE_W-1:0]])
            return r;
        x  = {1'b0, a};
        y  = b;
        dx = tree_depth[a];
        dy = tree_depth[b[NODE_W-1:0]];
        if (dx > dy)
            x = lift_node(x, dx - dy);
        else if (dy > dx)
            y = lift_node(y, dy - dx);
        if (x != y)
        begin
            for (int k = LEVELS - 1; k > 0; k--)
            begin
                ux = hop(x, k - 1);
                uy = hop(y, k - 1);
                if (ux != uy)
                begin
                    x = ux;
                    y = uy;
                end
            end
            x = hop(x, 0);
        end
        if (x < NODES)
        begin
            r.anc = x[OUT_W-1:0];
            r.err = 1'b0;
        end
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones, and calm stretches
    function automatic int pick_gap();
        int p;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 2)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [NODE_W-1:0] fresh_node();
        if (pool_pos < NODES)
        begin
            pool_pos++;
            return fresh_pool[pool_pos - 1];
        end
        return NODE_W'($urandom_range(0, NODES - 1));
    endfunction

    task automatic send_word(input logic f, input logic [NODE_W-1:0] a,
                             input logic [PARENT_W-1:0] b, input logic [DEPTH_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        node_a     <= a;
        node_b     <= b;
        node_depth <= d;
        do @(posedge clk); while (busy);
        if (f == FUNC_ADD)
            record_add(a, b, d);
        else
            answer_q.push_back(answer_query(a, b));
    endtask

    task automatic test_directed_cases();
        send_word(FUNC_QUERY, 10'd3, 11'd4, 10'd0);         // empty tree
        send_word(FUNC_ADD, 10'd5, NO_NODE, 10'd0);
        send_word(FUNC_ADD, 10'd1023, 11'd2047, 10'd0);     // root by all-ones parent
        send_word(FUNC_ADD, 10'd0, 11'd5, 10'd1);
        send_word(FUNC_ADD, 10'd6, 11'd0, 10'd2);
        send_word(FUNC_ADD, 10'd9, 11'd5, 10'd1);
        send_word(FUNC_QUERY, 10'd6, 11'd9, 10'd0);
        send_word(FUNC_QUERY, 10'd0, 11'd6, 10'd0);
        send_word(FUNC_QUERY, 10'd6, 11'd6, 10'd1023);
        send_word(FUNC_QUERY, 10'd6, 11'd1023, 10'd0);      // separate trees
        send_word(FUNC_QUERY, 10'd6, NO_NODE, 10'd0);
        send_word(FUNC_QUERY, 10'd1023, 11'd2047, 10'd0);
        send_word(FUNC_QUERY, 10'd6, 11'd3, 10'd0);         // unloaded second node
        send_word(FUNC_ADD, 10'd7, 11'd300, 10'd1023);      // unloaded parent, bogus depth
        send_word(FUNC_QUERY, 10'd7, 11'd5, 10'd0);         // lifts off the top
        send_word(FUNC_QUERY, 10'd6, 11'd7, 10'd0);
        send_word(FUNC_ADD, 10'd0, 11'd1023, 10'd1);        // node moved to another tree
        send_word(FUNC_QUERY, 10'd0, 11'd1023, 10'd0);
        send_word(FUNC_QUERY, 10'd6, 11'd9, 10'd0);
        send_word(FUNC_ADD, 10'd512, NO_NODE, 10'd682);
        send_word(FUNC_QUERY, 10'd512, 11'd1023, 10'd341);
        send_word(FUNC_QUERY, 10'd9, 11'd0, 10'd0);
    endtask

    task automatic test_random_forest(input int adds, input int queries, input int chain_pct);
        logic [NODE_W-1:0]   members [$];
        logic [NODE_W-1:0]   node, other;
        logic [PARENT_W-1:0] parent;
        logic [DEPTH_W-1:0]  d;
        int                  left_add, left_query, pick;
        left_add   = adds;
        left_query = queries;
        while (left_add + left_query > 0)
        begin
            pick = $urandom_range(0, 99);
            if (left_add > 0 && (members.size() < 2 || left_query == 0 || pick < 66))
            begin
                left_add--;
                node = fresh_node();
                pick = $urandom_range(0, 99);
                if (members.size() == 0 || pick < 4)
                begin
                    parent = NO_NODE | PARENT_W'($urandom_range(0, NODES - 1));
                    d      = '0;
                end
                else if (pick < 8)
                begin
                    // malformed add: any parent, any depth
                    parent = PARENT_W'($urandom_range(0, 2047));
                    d      = DEPTH_W'($urandom_range(0, 1023));
                end
                else
                begin
                    if ($urandom_range(0, 99) < chain_pct)
                        other = members[members.size() - 1];
                    else
                        other = members[$urandom_range(0, members.size() - 1)];
                    parent = {1'b0, other};
                    d      = tree_depth[other] + 10'd1;
                end
                send_word(FUNC_ADD, node, parent, d);
                members.push_back(node);
            end
            else
            begin
                left_query--;
                if (pick < 90)
                begin
                    node  = members[$urandom_range(0, members.size() - 1)];
                    other = members[$urandom_range(0, members.size() - 1)];
                    send_word(FUNC_QUERY, node, {1'b0, other}, DEPTH_W'($urandom_range(0, 1023)));
                end
                else
                    send_word(FUNC_QUERY, NODE_W'($urandom_range(0, NODES - 1)),
                              PARENT_W'($urandom_range(0, 2047)),
                              DEPTH_W'($urandom_range(0, 1023)));
            end
        end
    endtask

    // each answer word is checked against the oldest prediction
    always @(posedge clk)
    begin
        lca_answer_t want;
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected answer, expected none, actual ancestor %0d error %0b",
                         $time, common_ancestor, query_error);
                mismatches++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (common_ancestor !== want.anc)
                begin
                    $display("%0t: common_ancestor expected %0d actual %0d",
                             $time, want.anc, common_ancestor);
                    mismatches++;
                end
                if (query_error !== want.err)
                begin
                    $display("%0t: query_error expected %0b actual %0b",
                             $time, want.err, query_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int                j;
        logic [NODE_W-1:0] t;
        for (int i = 0; i < NODES; i++)
            fresh_pool[i] = NODE_W'(i);
        for (int i = NODES - 1; i > 0; i--)
        begin
            j             = $urandom_range(0, i);
            t             = fresh_pool[i];
            fresh_pool[i] = fresh_pool[j];
            fresh_pool[j] = t;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_forest(380, 190, 80);
        test_random_forest(280, 140, 30);
        test_random_forest(100, 50, 5);

        start <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
